FILE: rtl/fbc_pkg.sv
// Shared types, constants and plane lookup functions for the frustum box cull test.
// No dependencies; every other file in rtl/ uses this package.
package fbc_pkg;

    localparam int COORD_W     = 32;                 // signed Q16.16
    localparam int NORM_W      = COORD_W + 1;        // sum or difference of two elements
    localparam int DIST_W      = NORM_W + 1;         // negated normal-like value
    localparam int PROD_W      = NORM_W + COORD_W;   // exact product, Q.32
    localparam int SUM_W       = PROD_W + 2;         // sum of three products
    localparam int FRAC_W      = 16;
    localparam int PLANE_COUNT = 6;
    localparam int AXIS_COUNT  = 3;

    typedef logic signed [COORD_W-1:0] q_t;
    typedef logic [2:0]                plane_id_t;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_TEST = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        VEC_X = 2'd0,
        VEC_Y = 2'd1,
        VEC_Z = 2'd2,
        VEC_W = 2'd3
    } vec_t;

    // one request as it travels down the cell chain
    typedef struct packed
    {
        op_t          opcode;
        vec_t         vector_select;
        q_t [3:0]     elem;      // [0] x .. [3] w
        q_t [2:0]     box_lo;
        q_t [2:0]     box_hi;
        logic         in_view;
    } item_t;

    // component k that pairs with w in this plane
    function automatic vec_t plane_axis(input plane_id_t plane);
        vec_t axis;
        case (plane)
            3'd0, 3'd1: axis = VEC_X;
            3'd2, 3'd3: axis = VEC_Y;
            default:    axis = VEC_Z;
        endcase
        return axis;
    endfunction

    // 1: normal is w + k, 0: normal is w - k
    function automatic logic plane_add(input plane_id_t plane);
        logic add;
        case (plane)
            3'd0, 3'd3, 3'd5: add = 1'b1;
            default:          add = 1'b0;
        endcase
        return add;
    endfunction

endpackage

FILE: rtl/fbc_if.sv
// Request and result channel interfaces (valid/ready with payload).
// Depends on fbc_pkg.
interface fbc_req_if;
    logic              valid;
    logic              ready;
    fbc_pkg::op_t      opcode;
    logic [1:0]        vector_select;
    logic signed [31:0] elem_x;
    logic signed [31:0] elem_y;
    logic signed [31:0] elem_z;
    logic signed [31:0] elem_w;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;

    modport source
    (
        output valid, opcode, vector_select, elem_x, elem_y, elem_z, elem_w,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );
    modport sink
    (
        input  valid, opcode, vector_select, elem_x, elem_y, elem_z, elem_w,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

interface fbc_res_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source
    (
        output valid, inside_res,
        input  ready
    );
    modport sink
    (
        input  valid, inside_res,
        output ready
    );
endinterface

FILE: rtl/fbc_cell.sv
// One clip-plane cell: holds its plane, tests a passing box in two stages.
// Depends on fbc_pkg.
module fbc_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  fbc_pkg::plane_id_t plane,
    input  logic               up_valid,
    input  fbc_pkg::item_t     up,
    output logic               down_valid,
    output fbc_pkg::item_t     down
);

    fbc_pkg::vec_t                      axis;
    logic                               add;
    logic signed [fbc_pkg::NORM_W-1:0]  w_ext;
    logic signed [fbc_pkg::NORM_W-1:0]  k_ext;
    logic signed [fbc_pkg::NORM_W-1:0]  plane_val;
    logic                               load_hit;

    // plane state: three normal components and the distance
    logic signed [fbc_pkg::NORM_W-1:0]  normal_reg [fbc_pkg::AXIS_COUNT];
    logic signed [fbc_pkg::DIST_W-1:0]  dist_reg;

    logic signed [fbc_pkg::PROD_W-1:0]  prod_next  [fbc_pkg::AXIS_COUNT];
    logic signed [fbc_pkg::PROD_W-1:0]  s1_prod_reg [fbc_pkg::AXIS_COUNT];
    logic signed [fbc_pkg::DIST_W-1:0]  s1_dist_reg;
    fbc_pkg::item_t                     s1_item_reg;
    logic                               s1_valid_reg;

    logic signed [fbc_pkg::SUM_W-1:0]   sum;
    logic signed [fbc_pkg::SUM_W-1:0]   thr;
    logic                               pass;
    fbc_pkg::item_t                     s2_item_next;
    fbc_pkg::item_t                     s2_item_reg;
    logic                               s2_valid_reg;

    always_comb
    begin
        axis      = fbc_pkg::plane_axis(plane);
        add       = fbc_pkg::plane_add(plane);
        w_ext     = fbc_pkg::NORM_W'($signed(up.elem[fbc_pkg::VEC_W]));
        k_ext     = fbc_pkg::NORM_W'($signed(up.elem[axis]));
        plane_val = add ? (w_ext + k_ext) : (w_ext - k_ext);
        load_hit  = en && up_valid && (up.opcode == fbc_pkg::OP_LOAD);
    end

    // loads update the plane in request order with the tests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < fbc_pkg::AXIS_COUNT; a++)
            begin
                normal_reg[a] <= '0;
            end
            dist_reg <= '0;
        end
        else if (load_hit)
        begin
            if (up.vector_select == fbc_pkg::VEC_W)
            begin
                dist_reg <= -fbc_pkg::DIST_W'(plane_val);
            end
            for (int a = 0; a < fbc_pkg::AXIS_COUNT; a++)
            begin
                if (up.vector_select == fbc_pkg::vec_t'(a))
                begin
                    normal_reg[a] <= plane_val;
                end
            end
        end
    end

    // stage 1: furthest corner per axis, exact products
    always_comb
    begin
        for (int a = 0; a < fbc_pkg::AXIS_COUNT; a++)
        begin
            if (normal_reg[a][fbc_pkg::NORM_W-1])
            begin
                prod_next[a] = normal_reg[a] * $signed(up.box_lo[a]);
            end
            else
            begin
                prod_next[a] = normal_reg[a] * $signed(up.box_hi[a]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= up_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg <= up;
            s1_dist_reg <= dist_reg;
            for (int a = 0; a < fbc_pkg::AXIS_COUNT; a++)
            begin
                s1_prod_reg[a] <= prod_next[a];
            end
            s2_item_reg <= s2_item_next;
        end
    end

    // stage 2: dot product against distance scaled to Q.32
    always_comb
    begin
        sum = fbc_pkg::SUM_W'(s1_prod_reg[0]) + fbc_pkg::SUM_W'(s1_prod_reg[1])
            + fbc_pkg::SUM_W'(s1_prod_reg[2]);
        thr = fbc_pkg::SUM_W'(s1_dist_reg) <<< fbc_pkg::FRAC_W;
        pass = sum > thr;
        s2_item_next = s1_item_reg;
        s2_item_next.in_view = s1_item_reg.in_view && pass;
    end

    assign down_valid = s2_valid_reg;
    assign down       = s2_item_reg;

endmodule

FILE: rtl/frustum_box_cull_test.sv
// Frustum culling of axis-aligned boxes: top level with the six-cell plane chain.
// Depends on fbc_pkg, fbc_req_if/fbc_res_if and fbc_cell.
// An accepted test request travels to its result on res through the plane chain
//   (two register stages in each of the six plane cells, then the output register).
// Throughput: one request per cycle, loads and tests alike; the chain stalls only
//   when a finished test reaches its end while the output register is still held.
// Reset: asynchronous, active low; all planes clear to zero (all-zero matrix).
module frustum_box_cull_test
(
    input  logic       clk,
    input  logic       rst_n,
    fbc_req_if.sink    req,
    fbc_res_if.source  res
);

    // chain[i] feeds cell i; chain[PLANE_COUNT] is the tail
    fbc_pkg::item_t chain       [fbc_pkg::PLANE_COUNT+1];
    logic           chain_valid [fbc_pkg::PLANE_COUNT+1];

    logic           en;
    logic           tail_test;
    logic           out_free;
    logic           take;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           out_inside_reg;

    // Request entering the chain. Each load is handed down all six cells so that
    // every plane picks up its share of the new matrix vector in order with the
    // tests around it; a test starts out as inside and each cell may clear that.
    always_comb
    begin
        chain_valid[0]        = req.valid;
        chain[0].opcode       = req.opcode;
        chain[0].vector_select = fbc_pkg::vec_t'(req.vector_select);
        chain[0].elem[0]      = req.elem_x;
        chain[0].elem[1]      = req.elem_y;
        chain[0].elem[2]      = req.elem_z;
        chain[0].elem[3]      = req.elem_w;
        chain[0].box_lo[0]    = req.box_min_x;
        chain[0].box_lo[1]    = req.box_min_y;
        chain[0].box_lo[2]    = req.box_min_z;
        chain[0].box_hi[0]    = req.box_max_x;
        chain[0].box_hi[1]    = req.box_max_y;
        chain[0].box_hi[2]    = req.box_max_z;
        chain[0].in_view      = 1'b1;
    end

    for (genvar i = 0; i < fbc_pkg::PLANE_COUNT; i++)
    begin : g_cell
        fbc_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .plane      (fbc_pkg::plane_id_t'(i)),
            .up_valid   (chain_valid[i]),
            .up         (chain[i]),
            .down_valid (chain_valid[i+1]),
            .down       (chain[i+1])
        );
    end

    // Only a test at the tail needs the output register; loads drop off the end.
    // The whole chain advances unless a finished test cannot move out.
    always_comb
    begin
        tail_test = chain_valid[fbc_pkg::PLANE_COUNT]
                    && (chain[fbc_pkg::PLANE_COUNT].opcode == fbc_pkg::OP_TEST);
        out_free  = !out_valid_reg || res.ready;
        en        = !tail_test || out_free;
        take      = en && tail_test;

        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_inside_reg <= chain[fbc_pkg::PLANE_COUNT].in_view;
        end
    end

    assign req.ready      = en;
    assign res.valid      = out_valid_reg;
    assign res.inside_res = out_inside_reg;

endmodule
